[rtl/bmscr_pkg.sv]
package bmscr_pkg;

    // screen window layout
    localparam int unsigned SCREEN_SIZE = 6912;
    localparam int unsigned BITMAP_SIZE = 6144;
    localparam int unsigned ADDR_W      = 13;

    // configuration registers
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Y = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MARGIN_RESET = 8'd20;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STORE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;     // zero one store entry, advance sweep
        logic capture;   // latch incoming transaction
        logic store;     // write captured byte into the store
        logic rd_first;  // first store read for this transaction
        logic emit;      // load the output register
        logic rd_next;   // read the next cell row
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_window;
        logic out_free;
        logic last;
    } dp_status_t;

    // 16-entry palette, upper half bright
    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h000080;
            4'd2:    rgb = 24'h800000;
            4'd3:    rgb = 24'h800080;
            4'd4:    rgb = 24'h008000;
            4'd5:    rgb = 24'h008080;
            4'd6:    rgb = 24'h808000;
            4'd7:    rgb = 24'h808080;
            4'd8:    rgb = 24'h000000;
            4'd9:    rgb = 24'h0000FF;
            4'd10:   rgb = 24'hFF0000;
            4'd11:   rgb = 24'hFF00FF;
            4'd12:   rgb = 24'h00FF00;
            4'd13:   rgb = 24'h00FFFF;
            4'd14:   rgb = 24'hFFFF00;
            4'd15:   rgb = 24'hFFFFFF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

[rtl/bitmap_attribute_screen_renderer_unit.sv]
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+----------------------------------------
// s_       | in        | s_valid / s_ready  | write_address[15:0], write_data[7:0]
// m_       | out       | m_valid / m_ready  | row_x, row_y, pixel_bits, ink/paper_rgb,
//          |           |                    | last_row
// cfg_     | in        | cfg_we, no wait    | cfg_index (0 margin_x, 1 margin_y), cfg_data
//
// one write transaction at a time, one store read per emitted row. a write is captured in
// idle, stored with its first store read, then its rows are loaded: one row for a bitmap
// write, eight for an attribute write; a write outside the window is dropped and emits nothing.
// after reset a clearing pass zeroes the 6912-byte store, one byte a cycle, with s_ready
// low until it is done; cfg writes are taken during it.
// an output register holds each row; m_ready low stalls the row sequencer, nothing lost.
module bitmap_attribute_screen_renderer_unit #(
    parameter int unsigned SCREEN_BASE = 16384
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // write transactions in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [15:0]                       s_write_address,
    input  logic [7:0]                        s_write_data,
    // pixel row transactions out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [8:0]                        m_row_x,
    output logic [8:0]                        m_row_y,
    output logic [7:0]                        m_pixel_bits,
    output logic [23:0]                       m_ink_rgb,
    output logic [23:0]                       m_paper_rgb,
    output logic                              m_last_row,
    // margin registers
    input  logic                              cfg_we,
    input  logic [bmscr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmscr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bmscr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: clear sweep, capture, store + first read, row emission
    bmscr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // window decode, shadow store, palette lookup, output register
    bmscr_dp #(
        .SCREEN_BASE (SCREEN_BASE)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_write_address (s_write_address),
        .s_write_data    (s_write_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row_x         (m_row_x),
        .m_row_y         (m_row_y),
        .m_pixel_bits    (m_pixel_bits),
        .m_ink_rgb       (m_ink_rgb),
        .m_paper_rgb     (m_paper_rgb),
        .m_last_row      (m_last_row)
    );

endmodule

[rtl/bmscr_ctrl.sv]
module bmscr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bmscr_pkg::dp_status_t  status,
    output bmscr_pkg::dp_cmd_t     cmd
);
    import bmscr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_STORE;
            end
            ST_STORE: begin
                state_next = status.in_window ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free && status.last) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_STORE: begin
                cmd.store    = status.in_window;
                cmd.rd_first = status.in_window;
            end
            ST_EMIT: begin
                cmd.emit    = status.out_free;
                cmd.rd_next = status.out_free && !status.last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/bmscr_dp.sv]
module bmscr_dp #(
    parameter int unsigned SCREEN_BASE = 16384
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bmscr_pkg::dp_cmd_t                   cmd,
    output bmscr_pkg::dp_status_t                status,
    input  logic [15:0]                          s_write_address,
    input  logic [7:0]                           s_write_data,
    input  logic                                 cfg_we,
    input  logic [bmscr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmscr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [8:0]                           m_row_x,
    output logic [8:0]                           m_row_y,
    output logic [7:0]                           m_pixel_bits,
    output logic [23:0]                          m_ink_rgb,
    output logic [23:0]                          m_paper_rgb,
    output logic                                 m_last_row
);
    import bmscr_pkg::*;

    localparam logic [16:0] BASE_EXT = 17'(SCREEN_BASE);

    // margins
    logic [7:0] margin_x_reg;
    logic [7:0] margin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_x_reg <= MARGIN_RESET;
            margin_y_reg <= MARGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MARGIN_X: margin_x_reg <= cfg_data;
                REG_MARGIN_Y: margin_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window decode and capture
    logic [16:0]       diff;
    logic              win_next;
    logic [ADDR_W-1:0] off_reg;
    logic [7:0]        data_reg;
    logic              win_reg;

    assign diff     = {1'b0, s_write_address} - BASE_EXT;
    assign win_next = !diff[16] && (diff[15:0] < 16'(SCREEN_SIZE));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            off_reg  <= diff[ADDR_W-1:0];
            data_reg <= s_write_data;
            win_reg  <= win_next;
        end
    end

    // clearing sweep
    logic [ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // address generation
    logic              is_attr;
    logic [9:0]        attr_ofs;
    logic [4:0]        cell_row;
    logic [2:0]        k_reg;
    logic [2:0]        rd_k;
    logic [ADDR_W-1:0] bm_attr_addr;
    logic [ADDR_W-1:0] cell_addr;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] mem_ra;
    logic [7:0]        mem_wd;

    assign is_attr      = off_reg >= ADDR_W'(BITMAP_SIZE);
    assign attr_ofs     = 10'(off_reg - ADDR_W'(BITMAP_SIZE));
    assign cell_row     = attr_ofs[9:5];
    assign rd_k         = cmd.rd_first ? 3'd0 : k_reg + 3'd1;
    // attribute of the cell a bitmap byte belongs to
    assign bm_attr_addr = ADDR_W'(BITMAP_SIZE)
                        + {3'b000, off_reg[12:11], off_reg[7:5], off_reg[4:0]};
    // bitmap byte of pixel line rd_k inside an attribute cell
    assign cell_addr    = {cell_row[4:3], rd_k, cell_row[2:0], off_reg[4:0]};

    assign mem_we = cmd.clear | cmd.store;
    assign mem_wa = cmd.clear ? clr_cnt_reg : off_reg;
    assign mem_wd = cmd.clear ? 8'h00 : data_reg;
    assign mem_re = cmd.rd_first | cmd.rd_next;
    assign mem_ra = is_attr ? cell_addr : bm_attr_addr;

    // screen store
    logic [7:0] mem [0:SCREEN_SIZE-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (mem_re) k_reg <= rd_k;
    end

    // row assembly
    logic [7:0] y_base;
    logic [7:0] pix;
    logic [7:0] attr;
    logic       last;

    assign y_base = is_attr ? {cell_row, k_reg}
                            : {off_reg[12:11], off_reg[7:5], off_reg[10:8]};
    assign pix    = is_attr ? rd_data_reg : data_reg;
    assign attr   = is_attr ? data_reg : rd_data_reg;
    assign last   = !is_attr || (k_reg == 3'd7);

    // output register
    logic        m_valid_reg;
    logic [8:0]  row_x_reg;
    logic [8:0]  row_y_reg;
    logic [7:0]  pix_reg;
    logic [23:0] ink_reg;
    logic [23:0] paper_reg;
    logic        last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            row_x_reg <= {1'b0, off_reg[4:0], 3'b000} + {1'b0, margin_x_reg};
            row_y_reg <= {1'b0, y_base} + {1'b0, margin_y_reg};
            pix_reg   <= pix;
            ink_reg   <= palette({attr[6], attr[2:0]});
            paper_reg <= palette({attr[6], attr[5:3]});
            last_reg  <= last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row_x      = row_x_reg;
    assign m_row_y      = row_y_reg;
    assign m_pixel_bits = pix_reg;
    assign m_ink_rgb    = ink_reg;
    assign m_paper_rgb  = paper_reg;
    assign m_last_row   = last_reg;

    assign status.clear_done = clr_cnt_reg == ADDR_W'(SCREEN_SIZE - 1);
    assign status.in_window  = win_reg;
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.last       = last;

endmodule
